FILE: rtl/lrb_pkg.sv
// Shared types and constants for the link reconnect backoff core.
// Beat layouts for the input and result channels, status codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package lrb_pkg;

  localparam int DELAY_BITS = 24;
  localparam int COUNT_BITS = 16;
  localparam int NOW_BITS   = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Operation codes carried in the input beat.
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Link status codes.
  localparam logic [1:0] LS_PENDING   = 2'd0;
  localparam logic [1:0] LS_CONNECTED = 2'd1;
  localparam logic [1:0] LS_FAILED    = 2'd2;
  localparam logic [1:0] LS_NO_NET    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BASE_DELAY = 1'b0;
  localparam logic CFG_MAX_DELAY  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [1:0]          link_status;
    logic [NOW_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            conn_state;
    logic                  issue_connect;
    logic                  retry_scheduled;
    logic                  link_up;
    logic [COUNT_BITS-1:0] retry_count;
  } out_item_t;

endpackage

FILE: rtl/link_reconnect_backoff_fsm_core.sv
// Link connection manager with capped exponential backoff, top level.
// Depends on lrb_pkg for the beat structs, status codes and register indexes.
`timescale 1ns / 1ps

// Every accepted input beat produces exactly one registered result beat. The
// state update is a single pass: one WIDE_BITS-wide add for the retry deadline,
// one wrap-safe subtract for the deadline check and one 25-bit compare for the
// capped doubling, all between the state registers and the result register. A
// new input beat can be accepted every cycle while the skid entry is empty. The
// result side has an output register backed by one skid entry, so an input beat
// is still taken while a result waits on out_stall; in_stall rises only once the
// skid entry is occupied. Configuration registers are written through
// cfg_we, cfg_index and cfg_data and should only change while the block is idle.
module link_reconnect_backoff_fsm_core
  import lrb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DELAY_BITS-1:0] cfg_data
);

  // The deadline sum is formed at a width that holds both the time input and
  // the delay, then reduced modulo 2^TIME_BITS.
  localparam int WIDE_BITS = (TIME_BITS > NOW_BITS) ? TIME_BITS : NOW_BITS;

  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_CONNECTED    = 3'd2,
    ST_DISCONNECTED = 3'd3,
    ST_FAILED       = 3'd4
  } state_t;

  // Configuration registers.
  logic [DELAY_BITS-1:0] base_delay;
  logic [DELAY_BITS-1:0] max_delay;

  // Connection state.
  state_t                state;
  logic [DELAY_BITS-1:0] retry_delay;
  logic [TIME_BITS-1:0]  retry_deadline;
  logic [COUNT_BITS-1:0] retries;

  state_t                state_next;
  logic [DELAY_BITS-1:0] retry_delay_next;
  logic [TIME_BITS-1:0]  retry_deadline_next;
  logic [COUNT_BITS-1:0] retries_next;

  // Result buffering: output register plus one skid entry.
  out_item_t skid_data;
  logic      skid_valid;
  out_item_t result;

  logic                  accept;
  logic                  out_free;
  logic [TIME_BITS-1:0]  now_t;
  logic [WIDE_BITS-1:0]  deadline_sum;
  logic [TIME_BITS-1:0]  since_deadline;
  logic                  deadline_hit;
  logic [DELAY_BITS:0]   delay_doubled;
  logic [DELAY_BITS-1:0] delay_capped;
  logic [COUNT_BITS-1:0] retries_inc;
  logic                  issue;
  logic                  sched;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Time arithmetic, modulo 2^TIME_BITS.
  assign deadline_sum = WIDE_BITS'(in_data.now_ms) + WIDE_BITS'(retry_delay);
  assign now_t        = TIME_BITS'(WIDE_BITS'(in_data.now_ms));
  // The deadline has passed when now minus deadline has its top bit clear, which
  // stays correct across a wrap of the free-running time.
  assign since_deadline = now_t - retry_deadline;
  assign deadline_hit   = !since_deadline[TIME_BITS-1];

  // Backoff step: double the delay and clamp it at the configured cap.
  assign delay_doubled = {retry_delay, 1'b0};
  assign delay_capped  = (delay_doubled < {1'b0, max_delay}) ?
                         delay_doubled[DELAY_BITS-1:0] : max_delay;
  assign retries_inc   = (retries == COUNT_MAX) ? retries : retries + 1'b1;

  always_comb begin
    state_next          = state;
    retry_delay_next    = retry_delay;
    retry_deadline_next = retry_deadline;
    retries_next        = retries;
    issue               = 1'b0;
    sched               = 1'b0;

    if (in_data.op == OP_START) begin
      // A start restarts the backoff from any state and connects at once.
      state_next       = ST_CONNECTING;
      retry_delay_next = base_delay;
      retries_next     = '0;
      issue            = 1'b1;
    end else begin
      case (state)
        ST_CONNECTING: begin
          if (in_data.link_status == LS_CONNECTED) begin
            state_next       = ST_CONNECTED;
            retry_delay_next = base_delay;
            retries_next     = '0;
          end else if (in_data.link_status == LS_FAILED ||
                       in_data.link_status == LS_NO_NET) begin
            state_next          = ST_FAILED;
            retries_next        = retries_inc;
            retry_deadline_next = deadline_sum[TIME_BITS-1:0];
            retry_delay_next    = delay_capped;
            sched               = 1'b1;
          end
        end
        ST_CONNECTED: begin
          if (in_data.link_status != LS_CONNECTED) begin
            state_next          = ST_DISCONNECTED;
            retries_next        = retries_inc;
            retry_deadline_next = deadline_sum[TIME_BITS-1:0];
            retry_delay_next    = delay_capped;
            sched               = 1'b1;
          end
        end
        ST_DISCONNECTED, ST_FAILED: begin
          if (deadline_hit) begin
            state_next = ST_CONNECTING;
            issue      = 1'b1;
          end
        end
        default: begin
          // Idle: polls leave everything unchanged.
        end
      endcase
    end

    result.conn_state      = 3'(state_next);
    result.issue_connect   = issue;
    result.retry_scheduled = sched;
    result.link_up         = (state_next == ST_CONNECTED) &&
                             (in_data.link_status == LS_CONNECTED);
    result.retry_count     = retries_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay     <= DELAY_BITS'(1000);
      max_delay      <= DELAY_BITS'(60000);
      state          <= ST_IDLE;
      retry_delay    <= '0;
      retry_deadline <= '0;
      retries        <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_DELAY: base_delay <= cfg_data;
          CFG_MAX_DELAY:  max_delay  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (accept) begin
        state          <= state_next;
        retry_delay    <= retry_delay_next;
        retry_deadline <= retry_deadline_next;
        retries        <= retries_next;
      end

      if (out_free) begin
        // The output register moves on: refill it from the skid entry first,
        // otherwise from the beat accepted this cycle.
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_data  <= result;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        // The output is held, so park the new result in the skid entry.
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
